[hdl/tvsyn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants, sine table and envelope step for the two-voice synthesizer.
package tvsyn_pkg;

	localparam int SINE_INDEX_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int QBITS           = SINE_INDEX_BITS - 2;
	localparam int QDEPTH          = 1 << QBITS;

	localparam logic [16:0]          FULL_SCALE = 17'd32768;
	localparam logic signed [13:0]   GAIN_Q16   = 14'sd4915;
	localparam longint unsigned      POLY_A     = 64'd102944;
	localparam longint unsigned      POLY_B     = 64'd42047;
	localparam longint unsigned      POLY_C     = 64'd4640;

	localparam int IQ_DEPTH = 4;
	localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_PHASE_STEP_A = 3'd0,
		REG_PHASE_STEP_B = 3'd1,
		REG_RATES_A      = 3'd2,
		REG_RATES_B      = 3'd3,
		REG_SUSTAIN_A    = 3'd4,
		REG_SUSTAIN_B    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] phase_step_a;
		logic [31:0] phase_step_b;
		logic [47:0] rates_a;
		logic [47:0] rates_b;
		logic [15:0] sustain_a;
		logic [15:0] sustain_b;
	} cfg_t;

	// One queued item, already classified by the front end.
	typedef struct packed {
		logic        restart;
		logic        gate;
		logic [31:0] start_phase;
	} item_t;

	typedef struct packed {
		logic [IQ_CNT_W-1:0] count;
	} iq_status_t;

	typedef struct packed {
		logic        decaying;
		logic [16:0] level;
	} env_t;

	typedef logic [14:0] sine_mag_t;
	typedef sine_mag_t sine_lut_t [QDEPTH];

	// Quarter-wave magnitudes for x = k / QDEPTH of a quarter turn, built at elaboration.
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t       lut;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned inner;
		longint unsigned t;
		for (int k = 0; k < QDEPTH; k++) begin
			x     = longint'(k) << (16 - QBITS);
			x2    = (x * x) >> 16;
			inner = POLY_B - ((x2 * POLY_C) >> 16);
			inner = POLY_A - ((x2 * inner) >> 16);
			t     = (x * inner) >> 16;
			t     = (t + 64'd1) >> 1;
			if (t > 64'd32767) begin
				t = 64'd32767;
			end
			lut[k] = sine_mag_t'(t);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

	// Signed Q1.15 sine of the top SINE_INDEX_BITS of the phase.
	function automatic logic signed [15:0] sine_of(logic [PHASE_BITS-1:0] phase);
		logic [SINE_INDEX_BITS-1:0] idx;
		logic [1:0]                 quad;
		logic [QBITS-1:0]           rem;
		logic [QBITS-1:0]           k;
		logic [15:0]                mag;
		idx  = phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
		quad = idx[SINE_INDEX_BITS-1 -: 2];
		rem  = idx[QBITS-1:0];
		k    = quad[0] ? (~rem + QBITS'(1)) : rem;
		// Mirrored quadrant at its edge lands on the peak, just past the table
		if (quad[0] && (rem == '0)) begin
			mag = 16'd32767;
		end else begin
			mag = {1'b0, SINE_LUT[k]};
		end
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

	// Linear ADSR step for one voice.
	function automatic env_t env_step(env_t cur, logic gate, logic rising,
			logic [47:0] rates, logic [15:0] sustain);
		env_t               nxt;
		logic [16:0]        e0;
		logic [16:0]        sus;
		logic [17:0]        up;
		logic signed [18:0] down;
		e0           = rising ? '0 : cur.level;
		nxt.decaying = rising ? 1'b0 : cur.decaying;
		sus          = ({1'b0, sustain} > FULL_SCALE) ? FULL_SCALE : {1'b0, sustain};
		if (gate) begin
			if (e0 >= FULL_SCALE) begin
				nxt.decaying = 1'b1;
			end
			if (!nxt.decaying) begin
				up        = {1'b0, e0} + {2'b0, rates[15:0]};
				nxt.level = (up > {1'b0, FULL_SCALE}) ? FULL_SCALE : up[16:0];
			end else begin
				down      = $signed({2'b0, e0}) - $signed({3'b0, rates[31:16]});
				nxt.level = (down < $signed({2'b0, sus})) ? sus : down[16:0];
			end
		end else begin
			down      = $signed({2'b0, e0}) - $signed({3'b0, rates[47:32]});
			nxt.level = (down < 19'sd0) ? '0 : down[16:0];
		end
		return nxt;
	endfunction

endpackage

[hdl/tvsyn_front.sv]
`timescale 1ns / 1ps
// Front end: accept input transactions, classify them and queue them for the engine.
module tvsyn_front
	import tvsyn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_opcode,
	input  logic        in_gate,
	input  logic [31:0] in_start_phase,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_pop,
	output iq_status_t  status
);

	item_t               mem_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0] wr_ptr_q;
	logic [IQ_PTR_W-1:0] rd_ptr_q;
	logic [IQ_CNT_W-1:0] count_q;
	logic                push;
	logic                pop;

	assign in_ready     = (count_q != IQ_CNT_W'(IQ_DEPTH));
	assign push         = in_valid && in_ready;
	assign item_valid   = (count_q != '0);
	assign pop          = item_pop && item_valid;
	assign item         = mem_q[rd_ptr_q];
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].restart     <= in_opcode;
			mem_q[wr_ptr_q].gate        <= in_gate;
			mem_q[wr_ptr_q].start_phase <= in_start_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + IQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + IQ_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + IQ_CNT_W'(1);
				2'b01:   count_q <= count_q - IQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/tvsyn_engine.sv]
`timescale 1ns / 1ps
// Back end: voice state, envelopes, sine lookup and the shared mix multiplier.
module tvsyn_engine
	import tvsyn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               item_valid,
	input  item_t              item,
	output logic               item_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [15:0] res_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL_A = 5'b00010,
		ST_MUL_B = 5'b00100,
		ST_GAIN  = 5'b01000,
		ST_OUT   = 5'b10000
	} eng_state_t;

	eng_state_t             state_q;
	logic [PHASE_BITS-1:0]  phase_a_q;
	logic [PHASE_BITS-1:0]  phase_b_q;
	env_t                   env_a_q;
	env_t                   env_b_q;
	logic                   prev_gate_q;
	logic signed [15:0]     sine_a_q;
	logic signed [15:0]     sine_b_q;
	logic signed [31:0]     prod_q;
	logic signed [31:0]     acc_q;
	logic signed [45:0]     gain_q;

	logic                   rising;
	env_t                   env_a_nxt;
	env_t                   env_b_nxt;
	logic signed [15:0]     mul_x;
	logic signed [17:0]     mul_y;
	logic signed [33:0]     mul_p;
	logic signed [45:0]     rounded;
	logic signed [45:0]     shifted;

	assign rising    = item.gate && !prev_gate_q;
	assign env_a_nxt = env_step(env_a_q, item.gate, rising, cfg.rates_a, cfg.sustain_a);
	assign env_b_nxt = env_step(env_b_q, item.gate, rising, cfg.rates_b, cfg.sustain_b);
	assign item_pop  = (state_q == ST_IDLE);

	// One multiplier serves both voices
	assign mul_x = (state_q == ST_MUL_A) ? sine_a_q : sine_b_q;
	assign mul_y = (state_q == ST_MUL_A) ? $signed({1'b0, env_a_q.level})
	                                     : $signed({1'b0, env_b_q.level});
	assign mul_p = mul_x * mul_y;

	// Round to nearest, ties up, and saturate
	assign rounded = gain_q + (46'sd1 <<< 30);
	assign shifted = rounded >>> 31;

	always_comb begin
		if (shifted > 46'sd32767) begin
			res_data = 16'sh7fff;
		end else if (shifted < -46'sd32768) begin
			res_data = 16'sh8000;
		end else begin
			res_data = shifted[15:0];
		end
	end

	assign res_valid = (state_q == ST_OUT);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sine_a_q <= sine_of(phase_a_q);
				sine_b_q <= sine_of(phase_b_q);
			end
			ST_MUL_A: prod_q <= mul_p[31:0];
			ST_MUL_B: acc_q  <= prod_q + mul_p[31:0];
			ST_GAIN:  gain_q <= acc_q * GAIN_Q16;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_a_q   <= '0;
			phase_b_q   <= '0;
			env_a_q     <= '0;
			env_b_q     <= '0;
			prev_gate_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.restart) begin
							phase_a_q   <= PHASE_BITS'(item.start_phase);
							phase_b_q   <= PHASE_BITS'(item.start_phase);
							env_a_q     <= '0;
							env_b_q     <= '0;
							prev_gate_q <= 1'b0;
						end else begin
							env_a_q     <= env_a_nxt;
							env_b_q     <= env_b_nxt;
							prev_gate_q <= item.gate;
							phase_a_q   <= phase_a_q + PHASE_BITS'(cfg.phase_step_a);
							phase_b_q   <= phase_b_q + PHASE_BITS'(cfg.phase_step_b);
							state_q     <= ST_MUL_A;
						end
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/two_voice_sine_adsr_synth.sv]
`timescale 1ns / 1ps
// Top level of the two-voice sine synthesizer with linear ADSR envelopes.
//
// Channel   Dir  Payload                                        Transaction
// s_*       in   tuser[0] opcode; tdata[0] gate, [32:1] phase   tick or restart
// m_*       out  tdata[15:0] sample_out (signed Q1.15)          one per tick
// cfg_*     in   cfg_index register, cfg_data value             register write
//
// A tick occupies the engine through these steps: pop it, update envelopes,
// read the sine table and advance phases, then two passes through the shared
// 16x18 multiplier, one gain multiply, and presenting the rounded sum until taken.
// A restart reloads phases and clears envelopes without leaving idle and produces no sample.
// Reset clears phases, envelopes, gate history, queue and output valid flag,
// and loads the register defaults; no clearing pass is needed.
// A four-deep input queue takes transactions while the engine or the output
// stalls; the output register frees the engine as soon as the sample is stored.
module two_voice_sine_adsr_synth
	import tvsyn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] gate, [32:1] start_phase, [39:33] zero
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	cfg_t               cfg_q;
	logic               item_valid;
	item_t              item;
	logic               item_pop;
	iq_status_t         iq_status;
	logic               res_valid;
	logic               res_ready;
	logic signed [15:0] res_data;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	// Register writes are always taken; software must write only while idle, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step_a <= '0;
			cfg_q.phase_step_b <= '0;
			cfg_q.rates_a      <= 48'h0001_0001_0001;
			cfg_q.rates_b      <= 48'h0001_0001_0001;
			cfg_q.sustain_a    <= 16'd32768;
			cfg_q.sustain_b    <= 16'd32768;
		end else if (cfg_valid) begin
			// Drop writes to unknown indexes
			unique case (cfg_reg_t'(cfg_index))
				REG_PHASE_STEP_A: cfg_q.phase_step_a <= cfg_data[31:0];
				REG_PHASE_STEP_B: cfg_q.phase_step_b <= cfg_data[31:0];
				REG_RATES_A:      cfg_q.rates_a      <= cfg_data;
				REG_RATES_B:      cfg_q.rates_b      <= cfg_data;
				REG_SUSTAIN_A:    cfg_q.sustain_a    <= cfg_data[15:0];
				REG_SUSTAIN_B:    cfg_q.sustain_b    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	tvsyn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_opcode      (s_tuser[0]),
		.in_gate        (s_tdata[0]),
		.in_start_phase (s_tdata[32:1]),
		.item_valid     (item_valid),
		.item           (item),
		.item_pop       (item_pop),
		.status         (iq_status)
	);

	tvsyn_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	// Output register: hold the sample until the downstream side takes it
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Queue never accepts past its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(iq_status.count == IQ_CNT_W'(IQ_DEPTH)) |-> !(s_tvalid && s_tready))
		else $error("input queue overflow");

	// Engine takes items only when the queue has one
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && item_valid) |-> (iq_status.count != '0))
		else $error("engine popped an empty queue");

	// A stalled engine result holds its value until the output register takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
		else $error("engine result changed while stalled");

	// A new sample enters the output register only from a finished engine result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(res_valid))
		else $error("output valid without engine result");

endmodule

[dv/two_voice_sine_adsr_synth_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-voice sine synthesizer with ADSR envelopes.
module two_voice_sine_adsr_synth_tb;
	import tvsyn_pkg::*;

	localparam bit OP_TICK    = 1'b0;
	localparam bit OP_RESTART = 1'b1;

	// Register indexes past the last real register; writes to them must be ignored.
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam int RESET_CYCLES     = 6;
	localparam int SETTLE_CYCLES    = 64;   // four queued restarts plus a tick in flight
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int LONG_HOLD_AFTER  = 400;  // samples received before the long back-pressure
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RAND_PHASES      = 6;
	localparam int ITEMS_PER_PHASE  = 250;

	typedef enum bit {ROW_REG, ROW_ITEM} row_kind_t;

	// One line of the directed table: a register write or an input transaction.
	// For an item, value[31:0] is the start phase; known marks a sample typed in by hand.
	typedef struct {
		row_kind_t          kind;
		logic [2:0]         reg_idx;
		logic [47:0]        value;
		bit                 opcode;
		bit                 gate;
		bit                 known;
		logic signed [15:0] sample;
	} stim_row_t;

	typedef struct {
		logic [PHASE_BITS-1:0] phase;
		int                    level;
		bit                    decaying;
	} voice_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [0] gate, [32:1] start_phase, [39:33] zero
	logic [0:0]  s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] sample_out
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	// Shadow copy of the block: registers, both voices and the gate history
	logic [31:0] step_a, step_b;
	logic [47:0] rates_a, rates_b;
	logic [15:0] sus_a, sus_b;
	voice_t      voice_a, voice_b;
	bit          last_gate;

	logic signed [15:0] pending_samples[$];
	int                 errors;
	int                 samples_seen;
	int                 quiet_cycles;
	int                 burst_left;
	bit                 long_hold_done;

	two_voice_sine_adsr_synth dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Quarter-wave polynomial sine of the top index bits, Q1.15.
	function automatic int sine_q15(logic [PHASE_BITS-1:0] ph);
		int unsigned     idx;
		int unsigned     quad;
		int unsigned     rem;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned inner;
		longint unsigned t;
		idx  = int'(ph >> (PHASE_BITS - SINE_INDEX_BITS));
		quad = (idx >> (SINE_INDEX_BITS - 2)) & 3;
		rem  = idx & ((1 << (SINE_INDEX_BITS - 2)) - 1);
		x    = longint'(rem) << (16 - (SINE_INDEX_BITS - 2));
		// Odd quadrants run the quarter wave backward
		if (quad[0]) begin
			x = 64'd65536 - x;
		end
		x2    = (x * x) >> 16;
		inner = POLY_B - ((x2 * POLY_C) >> 16);
		inner = POLY_A - ((x2 * inner) >> 16);
		t     = (x * inner) >> 16;
		t     = (t + 64'd1) >> 1;
		if (t > 64'd32767) begin
			t = 64'd32767;
		end
		return quad[1] ? -int'(t) : int'(t);
	endfunction

	// One linear ADSR step; step fields may exceed full scale and saturate.
	function automatic voice_t env_advance(voice_t v, bit gate, logic [47:0] rates,
			logic [15:0] sus_raw);
		int full;
		int atk;
		int dcy;
		int rel;
		int sus;
		full = int'(FULL_SCALE);
		atk  = int'(rates[15:0]);
		dcy  = int'(rates[31:16]);
		rel  = int'(rates[47:32]);
		sus  = (int'(sus_raw) > full) ? full : int'(sus_raw);
		if (gate) begin
			if (v.level >= full) begin
				v.decaying = 1'b1;
			end
			if (!v.decaying) begin
				v.level = (v.level + atk > full) ? full : v.level + atk;
			end else begin
				// Below sustain in decay jumps straight up to sustain
				v.level = (v.level - dcy < sus) ? sus : v.level - dcy;
			end
		end else begin
			v.level = (v.level - rel < 0) ? 0 : v.level - rel;
		end
		return v;
	endfunction

	// Sum both voices, scale by the mix gain, round half up and saturate.
	function automatic logic signed [15:0] mix_sample(voice_t a, voice_t b);
		longint acc;
		acc = longint'(sine_q15(a.phase)) * a.level + longint'(sine_q15(b.phase)) * b.level;
		acc = acc * longint'(GAIN_Q16) + (longint'(1) << 30);
		acc = acc >>> 31;
		if (acc > 32767) begin
			acc = 32767;
		end else if (acc < -32768) begin
			acc = -32768;
		end
		return 16'(acc);
	endfunction

	// Advance the shadow state by one accepted transaction.
	task automatic advance_synth(bit op, bit gate, logic [31:0] sp, output bit produced,
			output logic signed [15:0] smp);
		produced = 1'b0;
		smp      = '0;
		if (op == OP_RESTART) begin
			voice_a   = '{phase: PHASE_BITS'(sp), level: 0, decaying: 1'b0};
			voice_b   = '{phase: PHASE_BITS'(sp), level: 0, decaying: 1'b0};
			last_gate = 1'b0;
		end else begin
			// A rising gate restarts both envelopes from zero in attack
			if (gate && !last_gate) begin
				voice_a.level    = 0;
				voice_a.decaying = 1'b0;
				voice_b.level    = 0;
				voice_b.decaying = 1'b0;
			end
			voice_a       = env_advance(voice_a, gate, rates_a, sus_a);
			voice_b       = env_advance(voice_b, gate, rates_b, sus_b);
			smp           = mix_sample(voice_a, voice_b);
			produced      = 1'b1;
			voice_a.phase = voice_a.phase + PHASE_BITS'(step_a);
			voice_b.phase = voice_b.phase + PHASE_BITS'(step_b);
			last_gate     = gate;
		end
	endtask

	task automatic store_reg(logic [2:0] idx, logic [47:0] d);
		case (idx)
			REG_PHASE_STEP_A: step_a  = d[31:0];
			REG_PHASE_STEP_B: step_b  = d[31:0];
			REG_RATES_A:      rates_a = d;
			REG_RATES_B:      rates_b = d;
			REG_SUSTAIN_A:    sus_a   = d[15:0];
			REG_SUSTAIN_B:    sus_b   = d[15:0];
			default:          ;
		endcase
	endtask

	// Hold a write on the register channel until it is taken; leave valid high.
	task automatic write_reg(logic [2:0] idx, logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, d);
	endtask

	// Offer one transaction in the current burst, opening a new burst after a gap.
	task automatic offer_item(bit op, bit gate, logic [31:0] sp, bit known,
			logic signed [15:0] typed);
		int                 gap;
		bit                 produced;
		logic signed [15:0] smp;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, sp, gate};
		do @(posedge clk); while (!s_tready);
		advance_synth(op, gate, sp, produced, smp);
		if (produced) begin
			pending_samples.push_back(known ? typed : smp);
		end
	endtask

	// Drop valid, drain every expected sample, then let queued restarts finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic stim_row_t row_reg(logic [2:0] idx, logic [47:0] d);
		return '{kind: ROW_REG, reg_idx: idx, value: d, opcode: OP_TICK, gate: 1'b0,
			known: 1'b0, sample: '0};
	endfunction

	function automatic stim_row_t row_item(bit op, bit gate, logic [31:0] sp, bit known,
			logic signed [15:0] smp);
		return '{kind: ROW_ITEM, reg_idx: '0, value: {16'b0, sp}, opcode: op, gate: gate,
			known: known, sample: smp};
	endfunction

	// Mode 0 drives every register to its top value, mode 1 to zero, others random.
	function automatic logic [31:0] pick_step(int mode);
		if (mode == 0) begin
			return '1;
		end else if (mode == 1) begin
			return '0;
		end
		case ($urandom_range(0, 3))
			0:       return $urandom_range(1, 1 << 20);
			1:       return 32'h4000_0000 + $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_rate();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'($urandom_range(1, 64));
			4:       return 16'($urandom);
			default: return 16'($urandom_range(64, 8192));
		endcase
	endfunction

	function automatic logic [47:0] pick_rates(int mode);
		if (mode == 0) begin
			return '1;
		end else if (mode == 1) begin
			return '0;
		end
		return {pick_rate(), pick_rate(), pick_rate()};
	endfunction

	function automatic logic [15:0] pick_sustain(int mode);
		if (mode == 0) begin
			return '1;
		end else if (mode == 1) begin
			return '0;
		end
		case ($urandom_range(0, 4))
			0:       return 16'h8000;
			1:       return 16'h0000;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// Check every sample against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			samples_seen <= samples_seen + 1;
			if (pending_samples.size() == 0) begin
				$display("%0t ns: sample with nothing expected, expected none, got %0d",
					$time, $signed(m_tdata));
				errors <= errors + 1;
			end else if (m_tdata !== pending_samples[0]) begin
				$display("%0t ns: sample_out mismatch, expected %0d, got %0d",
					$time, pending_samples[0], $signed(m_tdata));
				errors <= errors + 1;
				void'(pending_samples.pop_front());
			end else begin
				void'(pending_samples.pop_front());
			end
		end
	end

	// End the run when no channel has moved a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Output side: stall on a rotating pattern, re-drawn when its countdown runs out, and once
	// hold off for a long stretch so the input queue fills and back-pressures.
	initial begin : receiver
		logic [15:0] pattern;
		int          left;
		m_tready = 1'b0;
		pattern  = '1;
		left     = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && samples_seen >= LONG_HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_done = 1'b1;
			end
			if (left == 0) begin
				left = 64;
				case ($urandom_range(0, 3))
					0:       pattern = '1;
					1:       pattern = 16'($urandom);
					2:       pattern = 16'($urandom | $urandom);
					default: pattern = 16'($urandom & $urandom) | 16'h0101;
				endcase
			end
			left--;
			m_tready <= pattern[0];
			pattern = {pattern[0], pattern[15:1]};
		end
	end

	initial begin : stimulus
		stim_row_t dir_rows[$];
		bit        writing;
		bit        note_on;
		int        gate_run;
		bit        op;
		bit        g;

		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		errors         = 0;
		samples_seen   = 0;
		quiet_cycles   = 0;
		burst_left     = 0;
		long_hold_done = 1'b0;
		writing        = 1'b0;
		note_on        = 1'b0;
		gate_run       = 0;

		// Register defaults and cleared voices, as after reset
		step_a    = '0;
		step_b    = '0;
		rates_a   = 48'h0001_0001_0001;
		rates_b   = 48'h0001_0001_0001;
		sus_a     = 16'h8000;
		sus_b     = 16'h8000;
		voice_a   = '{phase: '0, level: 0, decaying: 1'b0};
		voice_b   = '{phase: '0, level: 0, decaying: 1'b0};
		last_gate = 1'b0;

		// Defaults: zero envelope or zero phase gives silence
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b1, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b1, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'sd0));
		dir_rows.push_back(row_item(OP_RESTART, 1'b0, 32'h4000_0000, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_RESTART, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b1, 16'sd0));
		// Extreme steps, oversized attack and sustain, writes to spare indexes
		dir_rows.push_back(row_reg(REG_PHASE_STEP_A, 48'hFFFF_FFFF_FFFF));
		dir_rows.push_back(row_reg(REG_PHASE_STEP_B, 48'h0000_4000_0000));
		dir_rows.push_back(row_reg(REG_RATES_A, 48'hFFFF_FFFF_8000));
		dir_rows.push_back(row_reg(REG_RATES_B, 48'h0001_4000_FFFF));
		dir_rows.push_back(row_reg(REG_SUSTAIN_A, 48'h0000_0000_FFFF));
		dir_rows.push_back(row_reg(REG_SUSTAIN_B, 48'h0000_0000_0000));
		dir_rows.push_back(row_reg(REG_SPARE_6, 48'hFFFF_FFFF_FFFF));
		dir_rows.push_back(row_reg(REG_SPARE_7, 48'h1234_5678_9ABC));
		dir_rows.push_back(row_item(OP_RESTART, 1'b0, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		// Raise sustain under a decaying envelope: it must jump up to sustain
		dir_rows.push_back(row_reg(REG_SUSTAIN_B, 48'hFFFF_FFFF_6000));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_RESTART, 1'b1, 32'h8000_0000, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b0, 16'sd0));
		// Frozen envelope on A, all-ones steps on B, sustain exactly full scale
		dir_rows.push_back(row_reg(REG_RATES_A, 48'h0));
		dir_rows.push_back(row_reg(REG_SUSTAIN_A, 48'h0000_0000_8000));
		dir_rows.push_back(row_reg(REG_RATES_B, 48'hFFFF_FFFF_FFFF));
		dir_rows.push_back(row_reg(REG_PHASE_STEP_A, 48'h0));
		dir_rows.push_back(row_reg(REG_PHASE_STEP_B, 48'h0000_0000_0001));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b1, 32'h0, 1'b0, 16'sd0));
		dir_rows.push_back(row_item(OP_TICK, 1'b0, 32'h0, 1'b0, 16'sd0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; drain before each group of register writes
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (!writing) begin
					wait_idle();
					writing = 1'b1;
				end
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				if (writing) begin
					cfg_valid <= 1'b0;
					writing = 1'b0;
				end
				offer_item(dir_rows[i].opcode, dir_rows[i].gate, dir_rows[i].value[31:0],
					dir_rows[i].known, dir_rows[i].sample);
			end
		end

		// Random phases: new settings each time, then notes held for random runs
		// with a few stray gate flips and occasional restarts.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			write_reg(REG_PHASE_STEP_A, {16'($urandom), pick_step(ph)});
			write_reg(REG_PHASE_STEP_B, {16'($urandom), pick_step(ph)});
			write_reg(REG_RATES_A, pick_rates(ph));
			write_reg(REG_RATES_B, pick_rates(ph));
			write_reg(REG_SUSTAIN_A, {32'($urandom), pick_sustain(ph)});
			write_reg(REG_SUSTAIN_B, {32'($urandom), pick_sustain(ph)});
			write_reg(ph[0] ? REG_SPARE_7 : REG_SPARE_6, {16'($urandom), 32'($urandom)});
			cfg_valid <= 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 49) == 0) begin
					op = OP_RESTART;
					g  = 1'($urandom_range(0, 1));
				end else begin
					op = OP_TICK;
					if (gate_run == 0) begin
						note_on  = !note_on;
						gate_run = note_on ? $urandom_range(1, 120) : $urandom_range(1, 20);
					end
					gate_run--;
					g = note_on;
					if ($urandom_range(0, 19) == 0) begin
						g = 1'($urandom_range(0, 1));
					end
				end
				offer_item(op, g, $urandom, 1'b0, 16'sd0);
			end
		end

		wait_idle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
